// File: sv/page_map_lru_clean_first_macros.svh
// Assertion macros for the page map checker.
// Each macro assumes clk and rst are visible in the scope of its use.
`ifndef PAGE_MAP_LRU_CLEAN_FIRST_MACROS_SVH
`define PAGE_MAP_LRU_CLEAN_FIRST_MACROS_SVH

// same-cycle implication
`define PM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define PM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/pmlru_pkg.sv
// Shared constants, controller states and control structs for the page map.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pmlru_pkg;

  localparam int NUM_FRAMES = 16;
  localparam int FRAME_W    = 4;
  localparam int OFFSET_W   = 12;
  localparam int TAG_W      = 20;
  localparam int CNT_W      = 32;
  localparam int CFG_W      = 5;
  localparam int ADDR_W     = 32;
  localparam int PHYS_W     = 16;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } ctl_state_t;

  typedef struct packed {
    logic load;    // capture the input item, restart the scan
    logic step;    // examine one frame
    logic commit;  // update frame state and load the result register
  } ctl_cmd_t;

  typedef struct packed {
    logic scan_last;  // current scan index is the last active frame
  } ctl_status_t;

endpackage

`default_nettype wire

// File: sv/pmlru_ctrl.sv
// Controller: sequences accept, frame scan and commit; owns the result valid.
// Depends on pmlru_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pmlru_ctrl (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      in_valid,
  output logic                     in_ready,
  output logic                     out_valid,
  input  wire                      out_ready,
  input  pmlru_pkg::ctl_status_t   status,
  output pmlru_pkg::ctl_cmd_t      cmd
);
  import pmlru_pkg::*;

  ctl_state_t state, state_next;
  logic       out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.step = 1'b1;
        if (status.scan_last) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        // wait for the result register to free up
        if (!out_valid || out_ready) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    if (cmd.commit) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

endmodule

`default_nettype wire

// File: sv/pmlru_dp.sv
// Datapath: frame tables, scan trackers, counters and the result register.
// Depends on pmlru_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pmlru_dp (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                cfg_we,
  input  wire  [pmlru_pkg::CFG_W-1:0]        cfg_data,
  input  wire                                command,
  input  wire  [pmlru_pkg::ADDR_W-1:0]       access_addr,
  input  pmlru_pkg::ctl_cmd_t                cmd,
  output pmlru_pkg::ctl_status_t             status,
  output logic [pmlru_pkg::PHYS_W-1:0]       physical_address,
  output logic [pmlru_pkg::FRAME_W-1:0]      frame_index,
  output logic                               page_fault,
  output logic                               evicted,
  output logic                               dirty_victim,
  output logic [pmlru_pkg::CNT_W-1:0]        fault_total,
  output logic [pmlru_pkg::CNT_W-1:0]        dirty_evict_total
);
  import pmlru_pkg::*;

  // frame tables
  logic [TAG_W-1:0]   frame_tag   [NUM_FRAMES];
  logic [NUM_FRAMES-1:0] frame_used;
  logic [NUM_FRAMES-1:0] frame_clean;
  logic [CNT_W-1:0]   frame_age   [NUM_FRAMES];

  logic [CFG_W-1:0]   frames_in_use;
  logic [CNT_W-1:0]   access_counter;
  logic [CNT_W-1:0]   fault_counter;
  logic [CNT_W-1:0]   dirty_evict_counter;

  // captured item
  logic               is_write;
  logic [TAG_W-1:0]   tag;
  logic [OFFSET_W-1:0] offset;

  // scan trackers
  logic [FRAME_W-1:0] idx;
  logic [FRAME_W-1:0] last_idx;
  logic               hit_found, empty_found, clean_found, any_found;
  logic [FRAME_W-1:0] hit_idx, empty_idx, clean_idx, any_idx;
  logic [CNT_W-1:0]   clean_age, any_age;

  logic               cur_used, cur_clean, cur_match;
  logic [CNT_W-1:0]   cur_age;

  logic [FRAME_W-1:0] sel_frame;
  logic               sel_fault, sel_evict, sel_dirty;
  logic [CNT_W-1:0]   age_new;

  always_comb begin
    if (frames_in_use == '0) begin
      last_idx = '0;
    end else if (frames_in_use > CFG_W'(NUM_FRAMES)) begin
      last_idx = FRAME_W'(NUM_FRAMES - 1);
    end else begin
      last_idx = FRAME_W'(frames_in_use - CFG_W'(1));
    end
  end

  assign status.scan_last = (idx == last_idx);

  assign cur_used  = frame_used[idx];
  assign cur_clean = frame_clean[idx];
  assign cur_age   = frame_age[idx];
  assign cur_match = cur_used && (frame_tag[idx] == tag);

  // replacement choice: hit, else lowest empty, else LRU clean, else LRU of all
  always_comb begin
    sel_fault = 1'b0;
    sel_evict = 1'b0;
    sel_dirty = 1'b0;
    if (hit_found) begin
      sel_frame = hit_idx;
    end else if (empty_found) begin
      sel_fault = 1'b1;
      sel_frame = empty_idx;
    end else if (clean_found) begin
      sel_fault = 1'b1;
      sel_evict = 1'b1;
      sel_frame = clean_idx;
    end else begin
      sel_fault = 1'b1;
      sel_evict = 1'b1;
      sel_dirty = 1'b1;
      sel_frame = any_idx;
    end
  end

  assign age_new = access_counter + CNT_W'(1);

  // control state and tables with defined reset
  always_ff @(posedge clk) begin
    if (rst) begin
      frames_in_use       <= CFG_W'(NUM_FRAMES);
      frame_used          <= '0;
      frame_clean         <= '1;
      access_counter      <= '0;
      fault_counter       <= '0;
      dirty_evict_counter <= '0;
      for (int i = 0; i < NUM_FRAMES; i++) begin
        frame_age[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        frames_in_use <= cfg_data;
      end
      if (cmd.commit) begin
        access_counter       <= age_new;
        frame_age[sel_frame] <= age_new;
        if (sel_fault) begin
          fault_counter          <= fault_counter + CNT_W'(1);
          frame_used[sel_frame]  <= 1'b1;
          frame_clean[sel_frame] <= !is_write;
        end else if (is_write) begin
          frame_clean[sel_frame] <= 1'b0;
        end
        if (sel_dirty) begin
          dirty_evict_counter <= dirty_evict_counter + CNT_W'(1);
        end
      end
    end
  end

  // payload: item capture, scan trackers, tags, result register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      is_write    <= command;
      tag         <= access_addr[ADDR_W-1:OFFSET_W];
      offset      <= access_addr[OFFSET_W-1:0];
      idx         <= '0;
      hit_found   <= 1'b0;
      empty_found <= 1'b0;
      clean_found <= 1'b0;
      any_found   <= 1'b0;
    end
    if (cmd.step) begin
      idx <= idx + FRAME_W'(1);
      if (cur_match && !hit_found) begin
        hit_found <= 1'b1;
        hit_idx   <= idx;
      end
      if (!cur_used && !empty_found) begin
        empty_found <= 1'b1;
        empty_idx   <= idx;
      end
      // strict less-than keeps the lowest frame on age ties
      if (cur_used && cur_clean && (!clean_found || cur_age < clean_age)) begin
        clean_found <= 1'b1;
        clean_age   <= cur_age;
        clean_idx   <= idx;
      end
      if (cur_used && (!any_found || cur_age < any_age)) begin
        any_found <= 1'b1;
        any_age   <= cur_age;
        any_idx   <= idx;
      end
    end
    if (cmd.commit) begin
      if (sel_fault) begin
        frame_tag[sel_frame] <= tag;
      end
      physical_address  <= {sel_frame, offset};
      frame_index       <= sel_frame;
      page_fault        <= sel_fault;
      evicted           <= sel_evict;
      dirty_victim      <= sel_dirty;
      fault_total       <= sel_fault ? fault_counter + CNT_W'(1) : fault_counter;
      dirty_evict_total <= sel_dirty ? dirty_evict_counter + CNT_W'(1)
                                     : dirty_evict_counter;
    end
  end

endmodule

`default_nettype wire

// File: sv/page_map_lru_clean_first.sv
// Top level of the page map with clean-first LRU replacement.
// Depends on pmlru_pkg, pmlru_ctrl and pmlru_dp.
//
//   channel  | handshake              | payload
//   ---------+------------------------+---------------------------------------
//   input    | in_valid / in_ready    | command, access_addr
//   result   | out_valid / out_ready  | physical_address, frame_index,
//            |                        | page_fault, evicted, dirty_victim,
//            |                        | fault_total, dirty_evict_total
//   config   | cfg_we                 | cfg_data (frames_in_use)
//
// Each item passes through an accept state, a serial scan that examines
// one active frame per cycle, and a commit state.
// The result register lets the next item be accepted and scanned while the
// previous result waits; commit stalls only while that result is still held.
// Reset is synchronous; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module page_map_lru_clean_first (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                cfg_we,
  input  wire  [pmlru_pkg::CFG_W-1:0]        cfg_data,
  input  wire                                in_valid,
  output logic                               in_ready,
  input  wire                                command,
  input  wire  [pmlru_pkg::ADDR_W-1:0]       access_addr,
  output logic                               out_valid,
  input  wire                                out_ready,
  output logic [pmlru_pkg::PHYS_W-1:0]       physical_address,
  output logic [pmlru_pkg::FRAME_W-1:0]      frame_index,
  output logic                               page_fault,
  output logic                               evicted,
  output logic                               dirty_victim,
  output logic [pmlru_pkg::CNT_W-1:0]        fault_total,
  output logic [pmlru_pkg::CNT_W-1:0]        dirty_evict_total
);
  import pmlru_pkg::*;

  ctl_cmd_t    cmd;
  ctl_status_t status;

  pmlru_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  pmlru_dp u_dp (
    .clk               (clk),
    .rst               (rst),
    .cfg_we            (cfg_we),
    .cfg_data          (cfg_data),
    .command           (command),
    .access_addr       (access_addr),
    .cmd               (cmd),
    .status            (status),
    .physical_address  (physical_address),
    .frame_index       (frame_index),
    .page_fault        (page_fault),
    .evicted           (evicted),
    .dirty_victim      (dirty_victim),
    .fault_total       (fault_total),
    .dirty_evict_total (dirty_evict_total)
  );

endmodule

`default_nettype wire

// File: sv/pmlru_checker.sv
// Port-level checks for the page map, bound to the top level.
// Depends on page_map_lru_clean_first_macros.svh and pmlru_pkg.
`timescale 1ns / 1ps
`default_nettype none
`include "page_map_lru_clean_first_macros.svh"

module pmlru_checker (
  input wire                            clk,
  input wire                            rst,
  input wire                            in_valid,
  input wire                            in_ready,
  input wire                            out_valid,
  input wire                            out_ready,
  input wire [pmlru_pkg::PHYS_W-1:0]    physical_address,
  input wire [pmlru_pkg::FRAME_W-1:0]   frame_index,
  input wire                            page_fault,
  input wire                            evicted,
  input wire                            dirty_victim
);
  import pmlru_pkg::*;

  `PM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(physical_address), "result dropped or changed while stalled")
  `PM_ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready, "second item taken during a scan")
  `PM_ASSERT_NOW(a_frame_bits, out_valid, physical_address[PHYS_W-1:OFFSET_W] == frame_index, "physical address frame bits differ from frame index")
  `PM_ASSERT_NOW(a_hit_flags, out_valid && !page_fault, !evicted && !dirty_victim, "eviction flagged on a hit")
  `PM_ASSERT_NOW(a_dirty_evict, out_valid && dirty_victim, evicted, "dirty victim without eviction")

endmodule

bind page_map_lru_clean_first pmlru_checker u_pmlru_checker (
  .clk              (clk),
  .rst              (rst),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .physical_address (physical_address),
  .frame_index      (frame_index),
  .page_fault       (page_fault),
  .evicted          (evicted),
  .dirty_victim     (dirty_victim)
);

`default_nettype wire

// File: test/page_map_lru_clean_first_tb.sv
`timescale 1ns / 1ps
// Testbench for page_map_lru_clean_first: directed and random accesses checked against
// an in-bench LRU page-map predictor, with random stalls on both channels.
// Depends on pmlru_pkg and the page_map_lru_clean_first RTL.

module page_map_lru_clean_first_tb;
  import pmlru_pkg::*;

  localparam logic CMD_READ     = 1'b0;
  localparam logic CMD_WRITE    = 1'b1;
  localparam int   SETTLE_CYCLES = NUM_FRAMES + 8;
  localparam int   CYCLE_LIMIT   = 600000;
  localparam int   RAND_PHASES   = 11;
  localparam int   PHASE_ITEMS   = 150;

  typedef struct {
    logic              cmd;
    logic [ADDR_W-1:0] addr;
  } access_t;

  typedef struct {
    logic [PHYS_W-1:0]  phys;
    logic [FRAME_W-1:0] frame;
    logic               fault;
    logic               evict;
    logic               dirty;
    logic [CNT_W-1:0]   faults;
    logic [CNT_W-1:0]   dirty_evicts;
  } xlate_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_we = 1'b0;
  logic [CFG_W-1:0]    cfg_data = '0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic                command = CMD_READ;
  logic [ADDR_W-1:0]   access_addr = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [PHYS_W-1:0]   physical_address;
  logic [FRAME_W-1:0]  frame_index;
  logic                page_fault;
  logic                evicted;
  logic                dirty_victim;
  logic [CNT_W-1:0]    fault_total;
  logic [CNT_W-1:0]    dirty_evict_total;

  page_map_lru_clean_first DUT (
    .clk               (clk),
    .rst               (rst),
    .cfg_we            (cfg_we),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .command           (command),
    .access_addr       (access_addr),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .physical_address  (physical_address),
    .frame_index       (frame_index),
    .page_fault        (page_fault),
    .evicted           (evicted),
    .dirty_victim      (dirty_victim),
    .fault_total       (fault_total),
    .dirty_evict_total (dirty_evict_total)
  );

  // Predictor state: a shadow copy of the frame tables and counters
  logic [TAG_W-1:0] pm_tag   [NUM_FRAMES];
  logic             pm_used  [NUM_FRAMES];
  logic             pm_clean [NUM_FRAMES];
  logic [CNT_W-1:0] pm_age   [NUM_FRAMES];
  logic [CNT_W-1:0] pm_access_cnt;
  logic [CNT_W-1:0] pm_fault_cnt;
  logic [CNT_W-1:0] pm_dirty_cnt;
  logic [CFG_W-1:0] pm_frames_cfg;

  access_t pending_access [$];
  xlate_t  expected_xlate [$];
  access_t drv_item;

  int sent_count = 0;
  int accepted_count = 0;
  int result_count = 0;
  int rcv_seen = 0;
  int in_gap_left = 0;
  int in_gap_max = 16;
  int stall_left = 0;
  int out_stall_max = 16;
  int error_count = 0;
  int faults_seen = 0;
  int evicts_seen = 0;
  int dirty_seen = 0;
  int cfg_writes = 0;
  int cycle_count = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Test completed with failures");
      $finish;
    end
  end

  // LRU among used active frames; ties go to the lowest index
  function automatic int lru_frame(int n, bit clean_only, output bit found);
    int               pick;
    logic [CNT_W-1:0] best;
    pick  = 0;
    best  = '0;
    found = 1'b0;
    for (int i = 0; i < n; i++) begin
      if (pm_used[i] && (!clean_only || pm_clean[i]) && (!found || pm_age[i] < best)) begin
        found = 1'b1;
        best  = pm_age[i];
        pick  = i;
      end
    end
    return pick;
  endfunction

  function automatic xlate_t translate_access(logic cmd, logic [ADDR_W-1:0] addr);
    xlate_t           r;
    logic [TAG_W-1:0] page;
    int               n;
    int               frame;
    bit               hit;
    bit               found;
    page    = addr[ADDR_W-1:OFFSET_W];
    n       = (pm_frames_cfg == 0) ? 1 :
              (pm_frames_cfg > NUM_FRAMES) ? NUM_FRAMES : int'(pm_frames_cfg);
    frame   = 0;
    hit     = 1'b0;
    found   = 1'b0;
    r.fault = 1'b0;
    r.evict = 1'b0;
    r.dirty = 1'b0;
    pm_access_cnt++;
    for (int i = 0; i < n; i++) begin
      if (!hit && pm_used[i] && pm_tag[i] == page) begin
        hit   = 1'b1;
        frame = i;
      end
    end
    if (hit) begin
      if (cmd == CMD_WRITE) pm_clean[frame] = 1'b0;
    end else begin
      r.fault = 1'b1;
      pm_fault_cnt++;
      for (int i = 0; i < n; i++) begin
        if (!found && !pm_used[i]) begin
          found = 1'b1;
          frame = i;
        end
      end
      if (!found) begin
        r.evict = 1'b1;
        frame = lru_frame(n, 1'b1, found);
        if (!found) begin
          // every active frame is dirty: take the oldest of all
          r.dirty = 1'b1;
          pm_dirty_cnt++;
          frame = lru_frame(n, 1'b0, found);
        end
      end
      pm_tag[frame]   = page;
      pm_used[frame]  = 1'b1;
      pm_clean[frame] = (cmd == CMD_READ);
    end
    pm_age[frame]  = pm_access_cnt;
    r.frame        = frame[FRAME_W-1:0];
    r.phys         = {frame[FRAME_W-1:0], addr[OFFSET_W-1:0]};
    r.faults       = pm_fault_cnt;
    r.dirty_evicts = pm_dirty_cnt;
    return r;
  endfunction

  task automatic check_field(string label, logic [CNT_W-1:0] want, logic [CNT_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, label, want, got);
      error_count++;
    end
  endtask

  // Monitor: tracks config writes and accepted items, checks results
  always @(posedge clk) begin
    xlate_t want;
    if (rst) begin
      for (int i = 0; i < NUM_FRAMES; i++) begin
        pm_tag[i]   = '0;
        pm_used[i]  = 1'b0;
        pm_clean[i] = 1'b1;
        pm_age[i]   = '0;
      end
      pm_access_cnt = '0;
      pm_fault_cnt  = '0;
      pm_dirty_cnt  = '0;
      pm_frames_cfg = CFG_W'(NUM_FRAMES);
    end else begin
      if (cfg_we) pm_frames_cfg = cfg_data;
      if (out_valid && out_ready) begin
        result_count++;
        if (expected_xlate.size() == 0) begin
          $display("%0t: result with no item outstanding, expected none, actual frame %0d",
                   $time, frame_index);
          error_count++;
        end else begin
          want = expected_xlate.pop_front();
          check_field("physical_address", CNT_W'(want.phys), CNT_W'(physical_address));
          check_field("frame_index", CNT_W'(want.frame), CNT_W'(frame_index));
          check_field("page_fault", CNT_W'(want.fault), CNT_W'(page_fault));
          check_field("evicted", CNT_W'(want.evict), CNT_W'(evicted));
          check_field("dirty_victim", CNT_W'(want.dirty), CNT_W'(dirty_victim));
          check_field("fault_total", want.faults, fault_total);
          check_field("dirty_evict_total", want.dirty_evicts, dirty_evict_total);
          faults_seen += want.fault;
          evicts_seen += want.evict;
          dirty_seen  += want.dirty;
        end
      end
      if (in_valid && in_ready) begin
        expected_xlate.push_back(translate_access(command, access_addr));
        accepted_count++;
      end
    end
  end

  // Driver: one item at a time from the pending queue, random gap after each
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && accepted_count != sent_count) begin
      // hold until the item is taken
    end else if (in_gap_left > 0) begin
      in_valid <= 1'b0;
      in_gap_left--;
    end else if (pending_access.size() > 0) begin
      drv_item = pending_access.pop_front();
      command     <= drv_item.cmd;
      access_addr <= drv_item.addr;
      in_valid    <= 1'b1;
      sent_count++;
      in_gap_left = $urandom_range(0, in_gap_max);
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Receiver: random stall drawn after each result
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (result_count != rcv_seen) begin
        rcv_seen   = result_count;
        stall_left = $urandom_range(0, out_stall_max);
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic queue_access(logic cmd, logic [ADDR_W-1:0] addr);
    access_t a;
    a.cmd  = cmd;
    a.addr = addr;
    pending_access.push_back(a);
  endtask

  // Sender holds off until every expected result is back and the block is quiet
  task automatic settle_block();
    do @(negedge clk);
    while (pending_access.size() != 0 || accepted_count != sent_count ||
           expected_xlate.size() != 0 || in_valid);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_frames_cfg(logic [CFG_W-1:0] value);
    settle_block();
    cfg_data <= value;
    cfg_we   <= 1'b1;
    @(negedge clk);
    cfg_we   <= 1'b0;
    cfg_writes++;
  endtask

  // Mostly pages from a small working set so hits and evictions both occur
  task automatic queue_random_accesses(int count, int pool_size, int write_pct);
    logic [TAG_W-1:0]  pool [$];
    logic [ADDR_W-1:0] addr;
    logic              cmd;
    repeat (pool_size) pool.push_back(TAG_W'($urandom));
    for (int k = 0; k < count; k++) begin
      addr = $urandom;
      if ($urandom_range(0, 99) < 85)
        addr[ADDR_W-1:OFFSET_W] = pool[$urandom_range(0, pool_size - 1)];
      cmd = ($urandom_range(0, 99) < write_pct) ? CMD_WRITE : CMD_READ;
      queue_access(cmd, addr);
    end
  endtask

  initial begin
    int unsigned frames_plan [RAND_PHASES] = '{16, 3, 17, 1, 8, 0, 31, 5, 12, 2, 16};
    logic [CFG_W-1:0] cfg_val;
    int active;
    int write_pct;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: reset frame count, fills, hits, write marking
    queue_access(CMD_READ,  32'h0000_0000);
    queue_access(CMD_WRITE, 32'hFFFF_FFFF);
    queue_access(CMD_READ,  32'hFFFF_F000);
    queue_access(CMD_WRITE, 32'h0000_0ABC);
    queue_access(CMD_READ,  32'h8000_0555);
    write_frames_cfg(5'd2);
    // both active frames dirty: forced dirty eviction
    queue_access(CMD_READ,  32'h1234_5678);
    queue_access(CMD_WRITE, 32'h0000_0001);
    queue_access(CMD_READ,  32'h1234_5FFF);
    // the clean frame goes even though the dirty one is older
    queue_access(CMD_READ,  32'hABCD_E000);
    queue_access(CMD_WRITE, 32'hABCD_E123);
    // page held only in a frame outside the active count: a miss
    queue_access(CMD_READ,  32'h8000_0000);
    queue_access(CMD_READ,  32'h5555_5000);
    write_frames_cfg(5'd1);
    queue_access(CMD_WRITE, 32'h0000_0FFF);
    queue_access(CMD_READ,  32'h0000_1000);
    write_frames_cfg(5'd0);
    queue_access(CMD_READ,  32'h0000_1234);
    queue_access(CMD_WRITE, 32'h7FFF_F800);
    write_frames_cfg(5'd31);
    queue_access(CMD_READ,  32'h8000_0AAA);
    queue_access(CMD_READ,  32'hFFFF_F777);
    queue_access(CMD_WRITE, 32'h7FFF_F001);

    for (int p = 0; p < RAND_PHASES; p++) begin
      cfg_val = (p == RAND_PHASES - 1) ? CFG_W'($urandom_range(0, 31)) : CFG_W'(frames_plan[p]);
      write_frames_cfg(cfg_val);
      in_gap_max    = (p % 3 == 0) ? 0 : 16;
      out_stall_max = (p % 4 == 1) ? 0 : 16;
      active = (cfg_val == 0) ? 1 : (cfg_val > NUM_FRAMES) ? NUM_FRAMES : int'(cfg_val);
      case ($urandom_range(0, 2))
        0:       write_pct = 10;
        1:       write_pct = 50;
        default: write_pct = 90;
      endcase
      queue_random_accesses(PHASE_ITEMS / 2, $urandom_range(1, active + 3), write_pct);
      settle_block();
      queue_random_accesses(PHASE_ITEMS / 2, $urandom_range(1, active + 3), write_pct);
    end

    settle_block();
    $display("Checked %0d results across %0d frame-count writes.", result_count, cfg_writes);
    $display("Seen %0d faults, %0d evictions, %0d of them forced dirty.",
             faults_seen, evicts_seen, dirty_seen);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: page_map_lru_clean_first.f
+incdir+sv
sv/pmlru_pkg.sv
sv/pmlru_ctrl.sv
sv/pmlru_dp.sv
sv/page_map_lru_clean_first.sv
sv/pmlru_checker.sv
test/page_map_lru_clean_first_tb.sv
